>>> src/assert_macros.svh
// Assertion helpers: every check is sampled on the rising clock and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that when the antecedent holds, the consequent holds on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rrfp_pkg.sv
package rrfp_pkg;

	localparam int ByteW = 8;
	localparam int WordW = 16;
	localparam int PosW = 4;

	localparam logic [ByteW-1:0] HdrByte = 8'hAA;

	// Byte positions within the 12-byte frame
	localparam logic [PosW-1:0] PosHdr0 = 4'd0;
	localparam logic [PosW-1:0] PosHdr1 = 4'd1;
	localparam logic [PosW-1:0] PosIdHi = 4'd2;
	localparam logic [PosW-1:0] PosIdLo = 4'd3;
	localparam logic [PosW-1:0] PosStrHi = 4'd4;
	localparam logic [PosW-1:0] PosStrLo = 4'd5;
	localparam logic [PosW-1:0] PosRngHi = 4'd6;
	localparam logic [PosW-1:0] PosRngLo = 4'd7;
	localparam logic [PosW-1:0] PosCheck = 4'd11;

	localparam logic [WordW-1:0] MinStrengthRst = 16'd5;
	localparam logic [WordW-1:0] MinRangeRst = 16'd20;
	localparam logic [WordW-1:0] MaxRangeRst = 16'd9000;

	localparam int CfgIdxW = 2;

	typedef enum logic [CfgIdxW-1:0] {
		RegMinStrength = 2'd0,
		RegMinRange    = 2'd1,
		RegMaxRange    = 2'd2
	} cfg_reg_t;

endpackage

>>> src/radar_range_frame_parser.sv
// A result passes through the input register, which loads on the edge that accepts its
// checksum beat, and then through the result register.
// Throughput: one byte per cycle while no result waits; at most one result per 12-byte frame.
// Back-pressure on the result side stalls the input only while a result waits.
// Reset (arst_n low, asynchronous): header search restarts, limits return to
// 5 / 20 / 9000, no result pending.
`include "assert_macros.svh"

module radar_range_frame_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side: [7:0] rx_byte
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rrfp_pkg::ByteW-1:0]       s_tdata,
	// master side: [15:0] range_value, [31:16] signal_strength, [47:32] frame_id
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [3*rrfp_pkg::WordW-1:0]     m_tdata,
	// master side user: [0] range_ok
	output logic                             m_tuser,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rrfp_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [rrfp_pkg::WordW-1:0]       cfg_data
);

	logic                          valid_s1;
	logic [rrfp_pkg::ByteW-1:0]    byte_s1;

	logic [rrfp_pkg::PosW-1:0]     pos_q;
	logic [rrfp_pkg::ByteW-1:0]    sum_q;
	logic [rrfp_pkg::WordW-1:0]    id_q;
	logic [rrfp_pkg::WordW-1:0]    strength_q;
	logic [rrfp_pkg::WordW-1:0]    range_q;

	logic [rrfp_pkg::WordW-1:0]    min_strength_q;
	logic [rrfp_pkg::WordW-1:0]    min_range_q;
	logic [rrfp_pkg::WordW-1:0]    max_range_q;

	logic                          out_valid_q;
	logic                          out_ok_q;
	logic [rrfp_pkg::WordW-1:0]    out_range_q;
	logic [rrfp_pkg::WordW-1:0]    out_strength_q;
	logic [rrfp_pkg::WordW-1:0]    out_id_q;

	logic                          advance;
	logic                          step;
	logic                          at_check;
	logic                          emit;
	logic                          limits_ok;
	logic [rrfp_pkg::PosW-1:0]     pos_next;
	logic [rrfp_pkg::ByteW-1:0]    sum_base;

	assign advance   = !out_valid_q || m_tready;
	assign step      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign at_check  = pos_q >= rrfp_pkg::PosCheck;
	assign emit      = step && at_check && (sum_q == byte_s1);
	assign limits_ok = (strength_q > min_strength_q) && (range_q > min_range_q)
		&& (range_q < max_range_q);

	// the checksum covers frame bytes four to ten only
	assign sum_base = (pos_q == rrfp_pkg::PosHdr0) ? '0 : sum_q;

	always_comb begin
		priority if (at_check) begin
			pos_next = rrfp_pkg::PosHdr0;
		end else if (pos_q <= rrfp_pkg::PosHdr1) begin
			pos_next = (byte_s1 == rrfp_pkg::HdrByte) ? pos_q + 1'b1 : rrfp_pkg::PosHdr0;
		end else begin
			pos_next = pos_q + 1'b1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= rrfp_pkg::PosHdr0;
			sum_q <= '0;
		end else if (step) begin
			pos_q <= pos_next;
			if (pos_q >= rrfp_pkg::PosStrHi && !at_check) begin
				sum_q <= sum_base + byte_s1;
			end else begin
				sum_q <= sum_base;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			case (pos_q)
				rrfp_pkg::PosIdHi:  id_q[15:8]       <= byte_s1;
				rrfp_pkg::PosIdLo:  id_q[7:0]        <= byte_s1;
				rrfp_pkg::PosStrHi: strength_q[15:8] <= byte_s1;
				rrfp_pkg::PosStrLo: strength_q[7:0]  <= byte_s1;
				rrfp_pkg::PosRngHi: range_q[15:8]    <= byte_s1;
				rrfp_pkg::PosRngLo: range_q[7:0]     <= byte_s1;
				default: ;
			endcase
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_strength_q <= rrfp_pkg::MinStrengthRst;
			min_range_q    <= rrfp_pkg::MinRangeRst;
			max_range_q    <= rrfp_pkg::MaxRangeRst;
		end else if (cfg_valid && cfg_ready) begin
			case (rrfp_pkg::cfg_reg_t'(cfg_index))
				rrfp_pkg::RegMinStrength: min_strength_q <= cfg_data;
				rrfp_pkg::RegMinRange:    min_range_q    <= cfg_data;
				rrfp_pkg::RegMaxRange:    max_range_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_ok_q       <= limits_ok;
			out_range_q    <= limits_ok ? range_q : '0;
			out_strength_q <= strength_q;
			out_id_q       <= id_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {out_id_q, out_strength_q, out_range_q};

	`ASSERT_CLK(a_pos_range, pos_q <= rrfp_pkg::PosCheck, "position beyond checksum")
	`ASSERT_NEXT(a_frame_restart, step && at_check, pos_q == rrfp_pkg::PosHdr0, "no restart")
	`ASSERT_CLK(a_range_forced, !(m_tvalid && !m_tuser) || (m_tdata[15:0] == '0), "range kept")
	`ASSERT_CLK(a_stall_input, !(m_tvalid && !m_tready && valid_s1) || !s_tready, "not held")

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int CycleLimit = 400000;
	localparam int DrainLimit = 4000;
	localparam int SettleCycles = 6;
	// index with no register behind it; writes to it must leave the limits alone
	localparam logic [rrfp_pkg::CfgIdxW-1:0] RegSpare = 2'd3;

	typedef struct packed {
		logic                       range_ok;
		logic [rrfp_pkg::WordW-1:0] range_value;
		logic [rrfp_pkg::WordW-1:0] sig_strength;
		logic [rrfp_pkg::WordW-1:0] frame_id;
	} reading_t;

	class range_tracker;
		logic [rrfp_pkg::WordW-1:0] min_strength;
		logic [rrfp_pkg::WordW-1:0] min_range;
		logic [rrfp_pkg::WordW-1:0] max_range;
		logic [rrfp_pkg::PosW-1:0]  byte_pos;
		logic [rrfp_pkg::ByteW-1:0] sum;
		logic [rrfp_pkg::WordW-1:0] id_word;
		logic [rrfp_pkg::WordW-1:0] strength_word;
		logic [rrfp_pkg::WordW-1:0] range_word;
		reading_t                   expected_readings[$];
		int                         errors;

		function new();
			min_strength = rrfp_pkg::MinStrengthRst;
			min_range = rrfp_pkg::MinRangeRst;
			max_range = rrfp_pkg::MaxRangeRst;
			byte_pos = rrfp_pkg::PosHdr0;
			sum = '0;
			id_word = '0;
			strength_word = '0;
			range_word = '0;
			errors = 0;
		endfunction

		function void set_limit(logic [rrfp_pkg::CfgIdxW-1:0] idx,
			logic [rrfp_pkg::WordW-1:0] val);
			case (idx)
				rrfp_pkg::RegMinStrength: min_strength = val;
				rrfp_pkg::RegMinRange:    min_range = val;
				rrfp_pkg::RegMaxRange:    max_range = val;
				default: ;
			endcase
		endfunction

		function void note_byte(logic [rrfp_pkg::ByteW-1:0] b);
			reading_t r;
			if (byte_pos == rrfp_pkg::PosHdr0)
				sum = '0;
			if (byte_pos < rrfp_pkg::PosIdHi) begin
				// a wrong header byte is dropped, not retried as the first header byte
				byte_pos = (b == rrfp_pkg::HdrByte) ? byte_pos + 1'b1 : rrfp_pkg::PosHdr0;
				return;
			end
			if (byte_pos < rrfp_pkg::PosCheck) begin
				case (byte_pos)
					rrfp_pkg::PosIdHi:  id_word[15:8] = b;
					rrfp_pkg::PosIdLo:  id_word[7:0] = b;
					rrfp_pkg::PosStrHi: strength_word[15:8] = b;
					rrfp_pkg::PosStrLo: strength_word[7:0] = b;
					rrfp_pkg::PosRngHi: range_word[15:8] = b;
					rrfp_pkg::PosRngLo: range_word[7:0] = b;
					default: ;
				endcase
				if (byte_pos > rrfp_pkg::PosIdLo)
					sum = sum + b;
				byte_pos = byte_pos + 1'b1;
				return;
			end
			byte_pos = rrfp_pkg::PosHdr0;
			if (sum != b)
				return;
			r.range_ok = strength_word > min_strength && range_word > min_range &&
				range_word < max_range;
			r.range_value = r.range_ok ? range_word : '0;
			r.sig_strength = strength_word;
			r.frame_id = id_word;
			expected_readings.push_back(r);
		endfunction

		task flag_mismatch(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		task check_reading(reading_t got);
			reading_t want;
			if (expected_readings.size() == 0) begin
				flag_mismatch($sformatf("unexpected reading ok=%0b range=%0h str=%0h id=%0h",
					got.range_ok, got.range_value, got.sig_strength, got.frame_id));
				return;
			end
			want = expected_readings.pop_front();
			if (got.range_ok !== want.range_ok || got.range_value !== want.range_value ||
				got.sig_strength !== want.sig_strength || got.frame_id !== want.frame_id)
				flag_mismatch($sformatf({"reading ok=%0b range=%0h str=%0h id=%0h, ",
					"want ok=%0b range=%0h str=%0h id=%0h"},
					got.range_ok, got.range_value, got.sig_strength, got.frame_id,
					want.range_ok, want.range_value, want.sig_strength, want.frame_id));
		endtask
	endclass

	logic                             clk;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [rrfp_pkg::ByteW-1:0]       s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [3*rrfp_pkg::WordW-1:0]     m_tdata;
	logic                             m_tuser;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [rrfp_pkg::CfgIdxW-1:0]     cfg_index = '0;
	logic [rrfp_pkg::WordW-1:0]       cfg_data = '0;

	range_tracker tracker = new();
	bit quiet = 1'b0;
	int calm_left = 0;
	int bytes_sent = 0;
	int cycles = 0;

	radar_range_frame_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),     // [7:0] rx_byte
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),     // [15:0] range_value, [31:16] signal_strength, [47:32] frame_id
		.m_tuser   (m_tuser),     // [0] range_ok
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("radar_range_frame_parser verification failed");
			$finish;
		end
	end

	// result side: random stall bursts, calm stretches, none once quiet
	initial begin : result_sink
		int pick;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			pick = $urandom_range(0, 15);
			if (!quiet && pick < 3) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat (pick == 15 ? $urandom_range(20, 60) : 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_reading('{m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]});
	end

	task automatic send_byte(input logic [rrfp_pkg::ByteW-1:0] b);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_byte(b);
		bytes_sent++;
		if (quiet)
			return;
		if (calm_left > 0)
			calm_left--;
		else if ($urandom_range(0, 31) == 0)
			calm_left = $urandom_range(20, 60);
		else if ($urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// send the first len bytes of a frame; a corrupt frame carries a wrong checksum
	task automatic send_frame(input logic [rrfp_pkg::WordW-1:0] id,
		input logic [rrfp_pkg::WordW-1:0] strength,
		input logic [rrfp_pkg::WordW-1:0] rng, input logic [23:0] spare, input bit corrupt,
		input int len);
		logic [rrfp_pkg::ByteW-1:0] fb[12];
		logic [rrfp_pkg::ByteW-1:0] sum;
		fb[0] = rrfp_pkg::HdrByte;
		fb[1] = rrfp_pkg::HdrByte;
		{fb[2], fb[3]} = id;
		{fb[4], fb[5]} = strength;
		{fb[6], fb[7]} = rng;
		{fb[8], fb[9], fb[10]} = spare;
		sum = '0;
		for (int i = 4; i < 11; i++)
			sum = sum + fb[i];
		fb[11] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
		for (int i = 0; i < len; i++)
			send_byte(fb[i]);
	endtask

	task automatic program_limits(input logic [rrfp_pkg::WordW-1:0] strength_min,
		input logic [rrfp_pkg::WordW-1:0] range_min,
		input logic [rrfp_pkg::WordW-1:0] range_max,
		input bit touch_spare);
		logic [rrfp_pkg::CfgIdxW-1:0] idx[4];
		logic [rrfp_pkg::WordW-1:0]   val[4];
		int n;
		idx[0] = rrfp_pkg::RegMinStrength; val[0] = strength_min;
		idx[1] = rrfp_pkg::RegMinRange;    val[1] = range_min;
		idx[2] = rrfp_pkg::RegMaxRange;    val[2] = range_max;
		idx[3] = RegSpare;                 val[3] = 16'($urandom);
		n = touch_spare ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			tracker.set_limit(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// wait for every expected reading, then let the pipeline empty
	task automatic settle();
		int waited;
		s_tvalid <= 1'b0;
		waited = 0;
		while (tracker.expected_readings.size() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		if (tracker.expected_readings.size() != 0) begin
			tracker.flag_mismatch($sformatf("%0d readings never arrived",
				tracker.expected_readings.size()));
			tracker.expected_readings.delete();
		end
		repeat (SettleCycles) @(posedge clk);
	endtask

	// values at and around a limit, zero, all ones, or anything
	function automatic logic [rrfp_pkg::WordW-1:0] near(logic [rrfp_pkg::WordW-1:0] mark);
		case ($urandom_range(0, 6))
			0: return mark - 1'b1;
			1: return mark;
			2: return mark + 1'b1;
			3: return '0;
			4: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_traffic(input int n_bytes);
		int start;
		int kind;
		logic [rrfp_pkg::ByteW-1:0] b;
		logic [rrfp_pkg::WordW-1:0] rng;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			kind = $urandom_range(0, 19);
			rng = $urandom_range(0, 1) ? near(tracker.min_range) : near(tracker.max_range);
			if (kind < 14) begin
				send_frame(16'($urandom), near(tracker.min_strength), rng, 24'($urandom),
					$urandom_range(0, 7) == 0, 12);
			end else if (kind < 16) begin
				repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
			end else if (kind < 18) begin
				b = 8'($urandom);
				if (b == rrfp_pkg::HdrByte)
					b = b ^ 8'h01;
				send_byte(rrfp_pkg::HdrByte);
				send_byte(b);
			end else begin
				send_frame(16'($urandom), near(tracker.min_strength), rng, 24'($urandom),
					1'b0, $urandom_range(3, 11));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise, a broken second header, then one frame failing limits and one passing
		send_byte(8'h00);
		send_byte(rrfp_pkg::HdrByte);
		send_byte(8'h55);
		send_frame(16'hFFFF, 16'h0000, 16'hFFFF, 24'hFFFFFF, 1'b0, 12);
		send_frame(16'h0000, 16'h1234, 16'h0100, 24'h00A55A, 1'b0, 12);
		random_traffic(200);
		settle();

		program_limits(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
		random_traffic(200);
		settle();

		// nothing can pass; the spare index must not disturb the limits
		program_limits(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
		random_traffic(150);
		settle();

		program_limits(16'($urandom), 16'($urandom_range(0, 2000)),
			16'($urandom_range(2001, 65535)), 1'b0);
		random_traffic(300);
		settle();

		quiet = 1'b1;
		program_limits(16'($urandom_range(0, 100)), 16'($urandom_range(0, 500)),
			16'($urandom_range(500, 12000)), 1'b1);
		random_traffic(300);
		settle();

		if (tracker.errors == 0)
			$display("radar_range_frame_parser verification clean");
		else
			$display("radar_range_frame_parser verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/rrfp_pkg.sv
src/radar_range_frame_parser.sv
verif/tb.sv
